// ----- sv/fbfs_pkg.sv -----
`timescale 1ns / 1ps

package fbfs_pkg;

    localparam int DEF_MAX_FREE_BLOCKS = 64;
    localparam int DEF_ADDR_BITS       = 32;
    localparam int FIELD_W             = 32;
    localparam int LEN_W               = 7;
    localparam int MODE_W              = 2;

    localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] FIT_WORST = 2'd1;
    localparam logic [MODE_W-1:0] FIT_BEST  = 2'd2;

    localparam logic FUNC_SEARCH = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    typedef struct packed {
        logic               func;
        logic [FIELD_W-1:0] request_size;
        logic [FIELD_W-1:0] block_address;
        logic [FIELD_W-1:0] block_capacity;
    } fbfs_in_t;

    typedef struct packed {
        logic               found;
        logic [FIELD_W-1:0] found_address;
        logic [FIELD_W-1:0] found_capacity;
        logic [LEN_W-1:0]   list_length;
        logic               table_full;
        logic [FIELD_W-1:0] reuse_total;
    } fbfs_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INS,
        ST_INSC,
        ST_FIN
    } fbfs_state_t;

endpackage

// ----- sv/fbfs_ram.sv -----
`timescale 1ns / 1ps

module fbfs_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/fbfs_engine.sv -----
`timescale 1ns / 1ps

module fbfs_engine
    import fbfs_pkg::*;
#(
    parameter int MAX_FREE_BLOCKS = DEF_MAX_FREE_BLOCKS,
    parameter int ADDR_BITS       = DEF_ADDR_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start_acc,
    input  fbfs_in_t            cmd,
    input  logic [MODE_W-1:0]   fit_mode,
    output logic                busy,
    output logic                fin,
    output fbfs_out_t           res
);

    localparam int IDX_W = $clog2(MAX_FREE_BLOCKS);
    localparam int CNT_W = $clog2(MAX_FREE_BLOCKS + 1);
    localparam int ENT_W = ADDR_BITS + FIELD_W;

    fbfs_state_t state_reg, state_next;

    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic               is_ins_reg, is_ins_next;
    logic               full_reg, full_next;
    logic [FIELD_W-1:0] need_reg, need_next;
    logic [ADDR_BITS-1:0] naddr_reg, naddr_next;
    logic [FIELD_W-1:0] ncap_reg, ncap_next;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic               pend_reg, pend_next;
    logic               have_reg, have_next;
    logic [ADDR_BITS-1:0] best_addr_reg, best_addr_next;
    logic [FIELD_W-1:0] best_cap_reg, best_cap_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [FIELD_W-1:0] reuse_reg, reuse_next;

    logic               ram_we, ram_re;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    logic [ENT_W-1:0]   ram_wdata, ram_rdata;
    logic [ADDR_BITS-1:0] r_addr, cmd_addr;
    logic [FIELD_W-1:0] r_cap;
    logic               rd_scan, fits, take, shift, is_full;

    fbfs_ram #(
        .DEPTH (MAX_FREE_BLOCKS),
        .WIDTH (ENT_W)
    ) u_fbfs_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign r_addr  = ram_rdata[ENT_W-1:FIELD_W];
    assign r_cap   = ram_rdata[FIELD_W-1:0];
    assign rd_scan = (scan_reg < count_reg);
    assign fits    = (r_cap >= need_reg);
    assign shift   = (r_addr >= naddr_reg);
    assign is_full = (count_reg >= CNT_W'(MAX_FREE_BLOCKS));

    // incoming address fitted to the stored address width
    always_comb
    begin
        for (int i = 0; i < ADDR_BITS; i++)
        begin
            if (i < FIELD_W)
            begin
                cmd_addr[i] = cmd.block_address[i];
            end
            else
            begin
                cmd_addr[i] = 1'b0;
            end
        end
    end

    always_comb
    begin
        case (mode_reg)
            FIT_FIRST: take = fits && !have_reg;
            FIT_WORST: take = fits && (!have_reg || (r_cap > best_cap_reg));
            FIT_BEST:  take = fits && (!have_reg || (r_cap < best_cap_reg));
            default:   take = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_acc)
                begin
                    if (cmd.func == FUNC_INSERT)
                    begin
                        state_next = is_full ? ST_FIN : ST_INS;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!rd_scan && !pend_reg)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_INS:
            begin
                state_next = (j_reg == '0) ? ST_FIN : ST_INSC;
            end
            ST_INSC:
            begin
                if (!shift)
                begin
                    state_next = ST_FIN;
                end
                else if (j_reg <= IDX_W'(1))
                begin
                    state_next = ST_INS;
                end
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        mode_next      = mode_reg;
        is_ins_next    = is_ins_reg;
        full_next      = full_reg;
        need_next      = need_reg;
        naddr_next     = naddr_reg;
        ncap_next      = ncap_reg;
        scan_next      = scan_reg;
        pend_next      = 1'b0;
        have_next      = have_reg;
        best_addr_next = best_addr_reg;
        best_cap_next  = best_cap_reg;
        j_next         = j_reg;
        count_next     = count_reg;
        reuse_next     = reuse_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_acc)
                begin
                    mode_next      = fit_mode;
                    is_ins_next    = (cmd.func == FUNC_INSERT);
                    full_next      = (cmd.func == FUNC_INSERT) && is_full;
                    need_next      = cmd.request_size;
                    naddr_next     = cmd_addr;
                    ncap_next      = cmd.block_capacity;
                    scan_next      = '0;
                    have_next      = 1'b0;
                    best_addr_next = '0;
                    best_cap_next  = '0;
                    j_next         = count_reg[IDX_W-1:0];
                end
            end
            ST_SCAN:
            begin
                ram_re    = rd_scan;
                ram_raddr = scan_reg[IDX_W-1:0];
                pend_next = rd_scan;
                if (rd_scan)
                begin
                    scan_next = scan_reg + CNT_W'(1);
                end
                if (pend_reg && take)
                begin
                    have_next      = 1'b1;
                    best_addr_next = r_addr;
                    best_cap_next  = r_cap;
                end
            end
            ST_INS:
            begin
                if (j_reg == '0)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    ram_wdata = {naddr_reg, ncap_reg};
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = j_reg - IDX_W'(1);
                end
            end
            ST_INSC:
            begin
                // entry j-1 is on the read port; move it up or drop the new one in at j
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                if (shift)
                begin
                    ram_wdata = ram_rdata;
                    j_next    = j_reg - IDX_W'(1);
                    if (j_reg > IDX_W'(1))
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = j_reg - IDX_W'(2);
                    end
                end
                else
                begin
                    ram_wdata = {naddr_reg, ncap_reg};
                end
            end
            ST_FIN:
            begin
                if (is_ins_reg && !full_reg)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                if (have_reg)
                begin
                    reuse_next = reuse_reg + FIELD_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
            count_reg <= '0;
            reuse_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            count_reg <= count_next;
            reuse_reg <= reuse_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        is_ins_reg    <= is_ins_next;
        full_reg      <= full_next;
        need_reg      <= need_next;
        naddr_reg     <= naddr_next;
        ncap_reg      <= ncap_next;
        scan_reg      <= scan_next;
        have_reg      <= have_next;
        best_addr_reg <= best_addr_next;
        best_cap_reg  <= best_cap_next;
        j_reg         <= j_next;
    end

    // outputs
    always_comb
    begin
        busy = (state_reg != ST_IDLE);
        fin  = (state_reg == ST_FIN);
        res.found          = have_reg;
        res.found_capacity = best_cap_reg;
        res.table_full     = full_reg;
        res.reuse_total    = reuse_next;
        for (int i = 0; i < FIELD_W; i++)
        begin
            if (i < ADDR_BITS)
            begin
                res.found_address[i] = best_addr_reg[i];
            end
            else
            begin
                res.found_address[i] = 1'b0;
            end
        end
        for (int i = 0; i < LEN_W; i++)
        begin
            if (i < CNT_W)
            begin
                res.list_length[i] = count_next[i];
            end
            else
            begin
                res.list_length[i] = 1'b0;
            end
        end
    end

endmodule

// ----- sv/free_block_fit_search_top.sv -----
// Free block list with first, worst and best fit search. A transaction is
// accepted when start is high and busy is low; its result is shown on result
// for exactly one cycle with done high and cannot be held off. All table
// entries sit in a single-port-read memory and are visited one per cycle: a
// search reads every held block in turn, an insert at position p moves the
// held blocks from p upward by one place, and an insert on a full table is
// dropped. The result is shown in the first cycle with busy low again, so the
// next transaction can be accepted in that same cycle. fit_mode may be written
// only while busy is low and no result is pending.
`timescale 1ns / 1ps

module free_block_fit_search_top
    import fbfs_pkg::*;
#(
    parameter int MAX_FREE_BLOCKS = DEF_MAX_FREE_BLOCKS,
    parameter int ADDR_BITS       = DEF_ADDR_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  fbfs_in_t          cmd,
    output logic              done,
    output fbfs_out_t         result,
    input  logic              cfg_we,
    input  logic [MODE_W-1:0] cfg_data
);

    logic [MODE_W-1:0] fit_mode_reg;
    logic              done_reg;
    fbfs_out_t         result_reg;
    logic              eng_busy, eng_fin;
    fbfs_out_t         eng_res;

    fbfs_engine #(
        .MAX_FREE_BLOCKS (MAX_FREE_BLOCKS),
        .ADDR_BITS       (ADDR_BITS)
    ) u_fbfs_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start_acc (start && !eng_busy),
        .cmd       (cmd),
        .fit_mode  (fit_mode_reg),
        .busy      (eng_busy),
        .fin       (eng_fin),
        .res       (eng_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg <= FIT_FIRST;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                fit_mode_reg <= cfg_data;
            end
            done_reg <= eng_fin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_fin)
        begin
            result_reg <= eng_res;
        end
    end

    assign busy   = eng_busy;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- sv/fbfs_checker.sv -----
`timescale 1ns / 1ps

module fbfs_props
    import fbfs_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      done,
    input fbfs_out_t result
);

    // busy is raised in the cycle after a transaction is accepted
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

    // a result only follows a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("result without preceding work");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.found) |-> (result.found_address == '0 && result.found_capacity == '0))
        else $error("miss reports nonzero block");

    a_full_no_find: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.table_full) |-> !result.found)
        else $error("dropped insert reports a found block");

endmodule

bind free_block_fit_search_top fbfs_props u_fbfs_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
